@@ src/anchor_timestamp_matcher_defines.svh @@
// Assertion macros for the anchor timestamp matcher.
`ifndef ANCHOR_TIMESTAMP_MATCHER_DEFINES_SVH
`define ANCHOR_TIMESTAMP_MATCHER_DEFINES_SVH

// Clocked assertion, disabled during reset.
`define ATM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ATM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/atm_pkg.sv @@
`default_nettype none
package atm_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned WIN_W      = 20;
  localparam int unsigned AGE_W      = 24;
  localparam int unsigned CAMS_W     = 2;
  localparam int unsigned GAP_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned NUM_BUFS   = 4;
  localparam int unsigned SLOTS_DEF  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CAMS = 2'd2;

  localparam logic [WIN_W-1:0]  SYNC_WINDOW_RST = 20'd50000;
  localparam logic [AGE_W-1:0]  MAX_AGE_RST     = 24'd1000000;
  localparam logic [CAMS_W-1:0] ACTIVE_CAMS_RST = 2'd0;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_SYNC    = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        sensor_sel;
    logic [TIME_W-1:0] now_time;
    logic              frame_ok;
    logic [TAG_W-1:0]  frame_tag;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  anchor_tag;
    logic [TIME_W-1:0] anchor_time;
    logic              depth_found;
    logic [TAG_W-1:0]  depth_tag;
    logic [GAP_W-1:0]  depth_gap;
    logic              cam0_found;
    logic [TAG_W-1:0]  cam0_tag;
    logic [GAP_W-1:0]  cam0_gap;
    logic              cam1_found;
    logic [TAG_W-1:0]  cam1_tag;
    logic [GAP_W-1:0]  cam1_gap;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [TAG_W-1:0]  tag;
    logic              ok;
  } entry_t;

endpackage
`default_nettype wire

@@ src/atm_if.sv @@
`default_nettype none
interface atm_req_if;
  logic          valid;
  logic          ready;
  atm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atm_res_if;
  logic          valid;
  logic          ready;
  atm_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/anchor_timestamp_matcher.sv @@
// Anchor timestamp matcher.
// req (sink): one request per valid/ready handshake. A frame arrival stores
//   time, tag and valid mark in the ring of the selected sensor.
// res (source): one matched set per sync tick that finds an anchor and at
//   least one companion frame within the sync window.
// cfg_*: register writes, taken at any edge with cfg_we_i high.
// A sync tick runs one scan pass over all 4*SLOTS_PER_SENSOR slots of the
//   frame memory (stale drop, anchor pick, companion match), then, on a match,
//   one purge pass over the same slots. One memory read per cycle sets the pace.
// Reset clears all slot-used bits, ring pointers and registers at once; no
//   clearing pass is needed and the block is ready right after reset.
// A result waits in the output register while res.ready is low; the block
//   keeps taking requests, and stalls only before loading the next result.
`default_nettype none
module anchor_timestamp_matcher #(
  parameter int unsigned SLOTS_PER_SENSOR = atm_pkg::SLOTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  atm_req_if.sink                             req,
  atm_res_if.source                           res,
  input  wire logic                           cfg_we_i,
  input  wire logic [atm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [atm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned KW    = (SLOTS_PER_SENSOR > 1) ? $clog2(SLOTS_PER_SENSOR) : 1;
  localparam int unsigned DEPTH = atm_pkg::NUM_BUFS * SLOTS_PER_SENSOR;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [KW-1:0] K_LAST = KW'(SLOTS_PER_SENSOR - 1);
  localparam logic [KW:0]   K_SIZE = (KW+1)'(SLOTS_PER_SENSOR);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PURGE, ST_OUT} state_e;

  state_e state_q;

  atm_pkg::entry_t mem_q [DEPTH];
  atm_pkg::entry_t rd_q;

  logic [DEPTH-1:0]                 used_q;
  logic [KW-1:0]                    oldest_q [atm_pkg::NUM_BUFS];
  logic [atm_pkg::WIN_W-1:0]        win_q;
  logic [atm_pkg::AGE_W-1:0]        age_q;
  logic [atm_pkg::CAMS_W-1:0]       cams_q;

  logic [1:0]                       b_q;
  logic [KW-1:0]                    n_q;
  logic                             iss_q;
  logic                             p_v_q;
  logic [1:0]                       p_b_q;
  logic [AW-1:0]                    p_addr_q;
  logic                             p_last_q;

  logic [atm_pkg::TIME_W-1:0]       now_q;
  logic                             have_a_q;
  logic [atm_pkg::TIME_W-1:0]       a_time_q;
  logic [atm_pkg::TAG_W-1:0]        a_tag_q;
  logic [atm_pkg::NUM_BUFS-1:0]     found_q;
  logic [atm_pkg::TIME_W-1:0]       m_time_q [atm_pkg::NUM_BUFS];
  logic [atm_pkg::TAG_W-1:0]        m_tag_q  [atm_pkg::NUM_BUFS];
  logic [atm_pkg::GAP_W-1:0]        m_gap_q  [atm_pkg::NUM_BUFS];

  logic [KW:0]                      ring_sum;
  logic [KW-1:0]                    ring_k;
  logic [AW-1:0]                    iss_addr;
  logic [AW-1:0]                    wr_addr;
  logic                             req_acc;
  logic                             wr_en;
  logic [1:0]                       cams_eff;
  logic                             act;
  logic                             used_rd;
  logic                             stale;
  logic                             live;
  logic [atm_pkg::TIME_W-1:0]       diff;
  logic                             cand_a;
  logic                             cand_m;
  logic [atm_pkg::TIME_W-1:0]       lim;
  logic                             purge_hit;
  logic                             any_found;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] b, input logic [KW-1:0] k);
    return AW'(b) * AW'(SLOTS_PER_SENSOR) + AW'(k);
  endfunction

  assign req_acc = req.valid && req.ready;
  assign wr_en   = req_acc && (req.data.req_type == atm_pkg::REQ_ARRIVAL);
  assign wr_addr = slot_addr(req.data.sensor_sel, oldest_q[req.data.sensor_sel]);
  assign req.ready = (state_q == ST_IDLE);

  always_comb begin
    ring_sum = {1'b0, oldest_q[b_q]} + {1'b0, n_q};
    if (ring_sum >= K_SIZE) begin
      ring_sum = ring_sum - K_SIZE;
    end
    ring_k   = ring_sum[KW-1:0];
    iss_addr = slot_addr(b_q, ring_k);
  end

  always_comb begin
    cams_eff  = (cams_q == 2'd3) ? 2'd2 : cams_q;
    act       = (p_b_q < 2'd2) || ((p_b_q - 2'd1) <= cams_eff);
    used_rd   = used_q[p_addr_q];
    stale     = used_rd && act &&
                (({1'b0, rd_q.ts} + 33'(age_q)) < {1'b0, now_q});
    live      = used_rd && !stale;
    diff      = (rd_q.ts > a_time_q) ? (rd_q.ts - a_time_q) : (a_time_q - rd_q.ts);
    cand_a    = (p_b_q == 2'd0) && live && (!have_a_q || (rd_q.ts > a_time_q));
    cand_m    = (p_b_q != 2'd0) && act && live && ((p_b_q == 2'd1) || rd_q.ok) &&
                (diff <= 32'(win_q)) &&
                (!found_q[p_b_q] || (diff[atm_pkg::GAP_W-1:0] < m_gap_q[p_b_q]));
    lim       = (p_b_q == 2'd0) ? a_time_q : m_time_q[p_b_q];
    purge_hit = used_rd && ((p_b_q == 2'd0) || found_q[p_b_q]) && (rd_q.ts <= lim);
    any_found = (|found_q[atm_pkg::NUM_BUFS-1:1]) || cand_m;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= '{ts: req.data.now_time, tag: req.data.frame_tag,
                          ok: req.data.frame_ok};
    end
    if (iss_q) begin
      rd_q <= mem_q[iss_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      oldest_q  <= '{default: '0};
      win_q     <= atm_pkg::SYNC_WINDOW_RST;
      age_q     <= atm_pkg::MAX_AGE_RST;
      cams_q    <= atm_pkg::ACTIVE_CAMS_RST;
      b_q       <= '0;
      n_q       <= '0;
      iss_q     <= 1'b0;
      p_v_q     <= 1'b0;
      p_b_q     <= '0;
      p_addr_q  <= '0;
      p_last_q  <= 1'b0;
      now_q     <= '0;
      have_a_q  <= 1'b0;
      a_time_q  <= '0;
      a_tag_q   <= '0;
      found_q   <= '0;
      m_time_q  <= '{default: '0};
      m_tag_q   <= '{default: '0};
      m_gap_q   <= '{default: '0};
      res.valid <= 1'b0;
      res.data  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          atm_pkg::CFG_SYNC_WINDOW: win_q  <= cfg_data_i[atm_pkg::WIN_W-1:0];
          atm_pkg::CFG_MAX_AGE:     age_q  <= cfg_data_i[atm_pkg::AGE_W-1:0];
          atm_pkg::CFG_ACTIVE_CAMS: cams_q <= cfg_data_i[atm_pkg::CAMS_W-1:0];
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end

      if (iss_q) begin
        p_v_q    <= 1'b1;
        p_b_q    <= b_q;
        p_addr_q <= iss_addr;
        p_last_q <= (b_q == 2'd3) && (n_q == K_LAST);
        if (n_q == K_LAST) begin
          n_q <= '0;
          b_q <= b_q + 2'd1;
          if (b_q == 2'd3) begin
            iss_q <= 1'b0;
          end
        end else begin
          n_q <= n_q + KW'(1);
        end
      end else begin
        p_v_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            if (req.data.req_type == atm_pkg::REQ_ARRIVAL) begin
              used_q[wr_addr] <= 1'b1;
              oldest_q[req.data.sensor_sel] <=
                (oldest_q[req.data.sensor_sel] == K_LAST) ? '0
                : oldest_q[req.data.sensor_sel] + KW'(1);
            end else begin
              now_q    <= req.data.now_time;
              have_a_q <= 1'b0;
              a_time_q <= '0;
              a_tag_q  <= '0;
              found_q  <= '0;
              b_q      <= '0;
              n_q      <= '0;
              iss_q    <= 1'b1;
              state_q  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (p_v_q) begin
            if (stale) begin
              used_q[p_addr_q] <= 1'b0;
            end
            if (cand_a) begin
              have_a_q <= 1'b1;
              a_time_q <= rd_q.ts;
              a_tag_q  <= rd_q.tag;
            end
            if (cand_m) begin
              found_q[p_b_q]  <= 1'b1;
              m_gap_q[p_b_q]  <= diff[atm_pkg::GAP_W-1:0];
              m_time_q[p_b_q] <= rd_q.ts;
              m_tag_q[p_b_q]  <= rd_q.tag;
            end
            if (p_last_q) begin
              if (have_a_q && any_found) begin
                b_q     <= '0;
                n_q     <= '0;
                iss_q   <= 1'b1;
                state_q <= ST_PURGE;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        ST_PURGE: begin
          if (p_v_q) begin
            if (purge_hit) begin
              used_q[p_addr_q] <= 1'b0;
            end
            if (p_last_q) begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid                <= 1'b1;
            res.data.anchor_tag      <= a_tag_q;
            res.data.anchor_time     <= a_time_q;
            res.data.depth_found     <= found_q[1];
            res.data.depth_tag       <= found_q[1] ? m_tag_q[1] : '0;
            res.data.depth_gap       <= found_q[1] ? m_gap_q[1] : '0;
            res.data.cam0_found      <= found_q[2];
            res.data.cam0_tag        <= found_q[2] ? m_tag_q[2] : '0;
            res.data.cam0_gap        <= found_q[2] ? m_gap_q[2] : '0;
            res.data.cam1_found      <= found_q[3];
            res.data.cam1_tag        <= found_q[3] ? m_tag_q[3] : '0;
            res.data.cam1_gap        <= found_q[3] ? m_gap_q[3] : '0;
            state_q                  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/atm_checker.sv @@
`default_nettype none
`include "anchor_timestamp_matcher_defines.svh"
module atm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_type_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic depth_found_i,
  input wire logic cam0_found_i,
  input wire logic cam1_found_i,
  input wire logic [atm_pkg::TAG_W-1:0] depth_tag_i,
  input wire logic [atm_pkg::GAP_W-1:0] depth_gap_i
);

  `ATM_ASSERT(a_res_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `ATM_ASSERT(a_res_match, out_valid_i |-> depth_found_i || cam0_found_i || cam1_found_i, "result without a match")
  `ATM_ASSERT(a_tick_busy, in_valid_i && in_ready_i && in_type_i |=> !in_ready_i, "sync tick took no scan cycles")
  `ATM_ASSERT(a_depth_zero, out_valid_i && !depth_found_i |-> depth_tag_i == '0 && depth_gap_i == '0, "unmatched depth fields not zero")
  `ATM_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind anchor_timestamp_matcher atm_checker u_atm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req.valid),
  .in_ready_i    (req.ready),
  .in_type_i     (req.data.req_type),
  .out_valid_i   (res.valid),
  .out_ready_i   (res.ready),
  .depth_found_i (res.data.depth_found),
  .cam0_found_i  (res.data.cam0_found),
  .cam1_found_i  (res.data.cam1_found),
  .depth_tag_i   (res.data.depth_tag),
  .depth_gap_i   (res.data.depth_gap)
);
`default_nettype wire
